>>> sv/spfsdl_pkg.sv
// Shared types and codes for the slot pool with free stack and dense live list.
`default_nettype none

package spfsdl_pkg;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_EXEC,
        S_REL2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  slot;
        logic [COUNT_W-1:0]  live_count;
        logic [COUNT_W-1:0]  free_count;
    } t_result;

endpackage

`default_nettype wire

>>> sv/spfsdl_req_if.sv
// Request and response channel interfaces for the slot pool.
`default_nettype none

interface spfsdl_req_if
    import spfsdl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  slot_index;
    logic [INDEX_W-1:0]  list_position;

    modport source (output valid, action, slot_index, list_position, input ready);
    modport sink   (input valid, action, slot_index, list_position, output ready);
endinterface

interface spfsdl_rsp_if
    import spfsdl_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  slot;
    logic [COUNT_W-1:0]  live_count;
    logic [COUNT_W-1:0]  free_count;

    modport source (output valid, status, slot, live_count, free_count, input ready);
    modport sink   (input valid, status, slot, live_count, free_count, output ready);
endinterface

`default_nettype wire

>>> sv/spfsdl_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module spfsdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sv/slot_pool_free_stack_dense_list.sv
// Slot pool: free stack and dense live list kept as one sparse set in two RAMs.
//
//   channel  | dir | fields                                   | handshake
//   ---------+-----+------------------------------------------+------------
//   i_req    | in  | action, slot_index, list_position        | valid/ready
//   o_rsp    | out | status, slot, live_count, free_count     | valid/ready
//
// Allocate and read pass through S_EXEC; release also needs S_REL2 (dependent
// read of the slot's position, then writes in S_EXEC and S_REL2 on the single
// RAM write ports). Clear sweeps both RAMs, one entry a cycle.
// After reset the same sweep runs with i_req.ready low.
// A result waiting in the output register holds the next finish in one spare
// stage; i_req.ready stays low until that stage is free again.
`default_nettype none

module slot_pool_free_stack_dense_list
    import spfsdl_pkg::*;
#(
    parameter int POOL_SLOTS = 64
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    spfsdl_req_if.sink   i_req,
    spfsdl_rsp_if.source o_rsp
);

    localparam int SW   = $clog2(POOL_SLOTS);
    localparam int CW   = $clog2(POOL_SLOTS + 1);
    localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

    // dense[j]: positions below live hold live slots, the rest hold the free
    // stack top-down. pos[s]: position of slot s in dense.
    logic          dense_we, pos_we;
    logic [SW-1:0] dense_waddr, dense_wdata, dense_raddr, dense_rdata;
    logic [SW-1:0] pos_waddr, pos_wdata, pos_raddr, pos_rdata;

    t_state        r_state, n_state;
    logic [CW-1:0] r_live, n_live;
    logic [SW-1:0] r_clr_cnt;
    logic          r_clr_reply;
    logic [ACTION_W-1:0] r_act;
    logic [SW-1:0] r_sidx;
    logic          r_bad;
    t_result       r_res, res, r_out;
    logic          r_out_valid;
    logic          finish, out_free, accept, clr_last, load_out, req_bad;

    spfsdl_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_dense (
        .i_clk   (i_clk),
        .i_we    (dense_we),
        .i_waddr (dense_waddr),
        .i_wdata (dense_wdata),
        .i_raddr (dense_raddr),
        .o_rdata (dense_rdata)
    );

    spfsdl_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_pos (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign clr_last    = (r_clr_cnt == SW'(POOL_SLOTS - 1));
    assign load_out    = (finish || (r_state == S_OUT)) && out_free;

    always_comb begin
        unique case (i_req.action)
            ACT_RELEASE: req_bad = CMPW'(i_req.slot_index) >= CMPW'(POOL_SLOTS);
            ACT_READ:    req_bad = CMPW'(i_req.list_position) >= CMPW'(r_live);
            default:     req_bad = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_req.action == ACT_CLEAR) ? S_CLR : S_EXEC;
                end
            end
            S_CLR: begin
                if (clr_last) begin
                    n_state = (r_clr_reply && !out_free) ? S_OUT : S_IDLE;
                end
            end
            S_EXEC: begin
                if (!finish) begin
                    n_state = S_REL2;
                end else begin
                    n_state = out_free ? S_IDLE : S_OUT;
                end
            end
            S_REL2: n_state = out_free ? S_IDLE : S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath controls and results
    always_comb begin
        dense_we    = 1'b0;
        dense_waddr = '0;
        dense_wdata = '0;
        pos_we      = 1'b0;
        pos_waddr   = '0;
        pos_wdata   = '0;
        dense_raddr = SW'(r_live);
        pos_raddr   = SW'(i_req.slot_index);
        finish      = 1'b0;
        res         = '0;
        n_live      = r_live;
        unique case (r_state)
            S_IDLE: begin
                unique case (i_req.action)
                    ACT_READ:    dense_raddr = SW'(i_req.list_position);
                    ACT_RELEASE: dense_raddr = SW'(r_live - 1'b1);
                    default:     dense_raddr = SW'(r_live);
                endcase
            end
            S_CLR: begin
                // free stack entry i holds i, stored top-down in dense
                dense_we    = 1'b1;
                dense_waddr = r_clr_cnt;
                dense_wdata = SW'(POOL_SLOTS - 1) - r_clr_cnt;
                pos_we      = 1'b1;
                pos_waddr   = SW'(POOL_SLOTS - 1) - r_clr_cnt;
                pos_wdata   = r_clr_cnt;
                if (clr_last) begin
                    n_live     = '0;
                    finish     = r_clr_reply;
                    res.status = ST_DONE;
                end
            end
            S_EXEC: begin
                unique case (r_act)
                    ACT_ALLOC: begin
                        finish = 1'b1;
                        if (r_live == CW'(POOL_SLOTS)) begin
                            res.status = ST_FULL;
                        end else begin
                            res.status = ST_DONE;
                            res.slot   = INDEX_W'(dense_rdata);
                            n_live     = r_live + 1'b1;
                        end
                    end
                    ACT_READ: begin
                        finish = 1'b1;
                        if (r_bad) begin
                            res.status = ST_IGNORED;
                        end else begin
                            res.status = ST_DONE;
                            res.slot   = INDEX_W'(dense_rdata);
                        end
                    end
                    ACT_RELEASE: begin
                        // slot is live when its position lies below the live count
                        if (r_bad || (CW'(pos_rdata) >= r_live)) begin
                            finish     = 1'b1;
                            res.status = ST_IGNORED;
                        end else begin
                            // last live entry moves into the hole
                            dense_we    = 1'b1;
                            dense_waddr = pos_rdata;
                            dense_wdata = dense_rdata;
                            pos_we      = 1'b1;
                            pos_waddr   = dense_rdata;
                            pos_wdata   = pos_rdata;
                        end
                    end
                    default: begin
                        finish     = 1'b1;
                        res.status = ST_DONE;
                    end
                endcase
            end
            S_REL2: begin
                // released slot lands on top of the free stack
                dense_we    = 1'b1;
                dense_waddr = SW'(r_live - 1'b1);
                dense_wdata = r_sidx;
                pos_we      = 1'b1;
                pos_waddr   = r_sidx;
                pos_wdata   = SW'(r_live - 1'b1);
                n_live      = r_live - 1'b1;
                finish      = 1'b1;
                res.status  = ST_DONE;
            end
            S_OUT: begin
                finish = 1'b0;
            end
            default: begin
                finish = 1'b0;
            end
        endcase
        res.live_count = COUNT_W'(n_live);
        res.free_count = COUNT_W'(CW'(POOL_SLOTS) - n_live);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_live      <= '0;
            r_clr_cnt   <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_live  <= n_live;
            if (r_state == S_CLR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (accept && (i_req.action == ACT_CLEAR)) begin
                r_clr_cnt   <= '0;
                r_clr_reply <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act  <= i_req.action;
            r_sidx <= SW'(i_req.slot_index);
            r_bad  <= req_bad;
        end
        if (finish && !out_free) begin
            r_res <= res;
        end
        if (load_out) begin
            r_out <= (r_state == S_OUT) ? r_res : res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.slot       = r_out.slot;
    assign o_rsp.live_count = r_out.live_count;
    assign o_rsp.free_count = r_out.free_count;

endmodule

`default_nettype wire
